// ----- src/npt_pkg.sv -----
// Package for the nearest point table: opcodes, status codes, state type and widths.
// Used by npt_sqrt and nearest_point_table; depends on nothing.
package npt_pkg;

    localparam int unsigned CoordW = 16;
    localparam int unsigned LimitW = 17;
    localparam int unsigned DistW  = 21;
    localparam int unsigned D2W    = 35;
    localparam int unsigned RadW   = 43;
    localparam int unsigned CountW = 11;
    localparam int unsigned StatW  = 2;
    localparam logic [LimitW-1:0] LimitReset = 17'd100000;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic [StatW-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_ROOT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
    } t_point;

endpackage

// ----- src/npt_sqrt.sv -----
// Iterative integer square root, one result bit per cycle, for the nearest point table.
// Depends on npt_pkg for the radicand and result widths.
module npt_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [npt_pkg::RadW-1:0]    i_radicand,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [npt_pkg::DistW:0]     o_root
);
    import npt_pkg::*;

    localparam int unsigned RootW = (RadW + 1) / 2;
    localparam int unsigned StepW = $clog2(RootW + 1);
    localparam int unsigned RemW  = RootW + 2;

    logic [RadW:0]       r_val;
    logic [RootW-1:0]    r_root;
    logic [RemW-1:0]     r_rem;
    logic [StepW-1:0]    r_steps;
    logic                r_busy;
    logic                r_done;
    logic [RemW-1:0]     n_trial;
    logic [RemW-1:0]     n_shift;

    // Restoring method: bring down two radicand bits, try subtracting 4*root+1.
    always_comb begin
        n_shift = {r_rem[RemW-3:0], r_val[RadW:RadW-1]};
        n_trial = n_shift - {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_val   <= {1'b0, i_radicand};
                r_root  <= '0;
                r_rem   <= '0;
                r_steps <= StepW'(RootW);
            end else if (r_busy) begin
                r_val <= {r_val[RadW-2:0], 2'b00};
                if (!n_trial[RemW-1]) begin
                    r_rem  <= n_trial;
                    r_root <= {r_root[RootW-2:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_root <= {r_root[RootW-2:0], 1'b0};
                end
                r_steps <= r_steps - 1'b1;
                if (r_steps == StepW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- src/nearest_point_table.sv -----
// Top level of the nearest point table: control, point memory and result register.
// Depends on npt_pkg and npt_sqrt.
//
// Keeps up to TABLE_DEPTH 3D points in one synchronous memory. An item occupies the
// block from its accept cycle until its result moves into the output register.
// Clear, add, and a delete or query on an empty table go straight to the final
// state. Delete and query walk the stored points one per cycle through the memory's
// single read port; a query that finds a point below search_limit then also runs
// the bit-serial square root. The next item is taken the cycle after. A finished
// result waits in an output register and does not block the input side; only a
// result still waiting when the next one is ready holds the block in its final
// state. Write search_limit only while the block is idle.
module nearest_point_table #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic signed [npt_pkg::CoordW-1:0] i_x_coord,
    input  logic signed [npt_pkg::CoordW-1:0] i_y_coord,
    input  logic signed [npt_pkg::CoordW-1:0] i_z_coord,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [npt_pkg::LimitW-1:0]    i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [npt_pkg::CoordW-1:0] o_near_x,
    output logic signed [npt_pkg::CoordW-1:0] o_near_y,
    output logic signed [npt_pkg::CoordW-1:0] o_near_z,
    output logic [npt_pkg::DistW-1:0]     o_near_distance,
    output logic [npt_pkg::CountW-1:0]    o_point_count,
    output logic [npt_pkg::StatW-1:0]     o_status
);
    import npt_pkg::*;

    localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);

    // Point memory, one read and one write port.
    t_point             mem [TABLE_DEPTH];
    t_point             r_rd_data;
    logic [AddrW-1:0]   n_rd_addr;
    logic               n_we;
    logic [AddrW-1:0]   n_wr_addr;
    t_point             n_wr_data;

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[n_wr_addr] <= n_wr_data;
        end
        r_rd_data <= mem[n_rd_addr];
    end

    t_state             r_state, n_state;
    logic [LimitW-1:0]  r_limit;
    logic [CntW-1:0]    r_count;
    t_opcode            r_op;
    t_point             r_key;
    logic [CntW-1:0]    r_rd_idx;
    logic               r_rd_live;
    logic [CntW-1:0]    r_chk_idx;
    logic [CntW-1:0]    r_kept;
    logic [D2W-1:0]     r_best;
    logic               r_found;
    t_point             r_pick;
    logic               r_first;
    t_point             r_res_pt;
    logic [DistW-1:0]   r_res_dist;
    t_status            r_res_status;
    logic               r_out_valid;
    t_point             r_out_pt;
    logic [DistW-1:0]   r_out_dist;
    logic [CntW-1:0]    r_out_count;
    t_status            r_out_status;

    logic               in_acc;
    logic               out_free;
    logic [D2W-1:0]     n_d2;
    logic               n_match;
    logic [CoordW:0]    dx, dy, dz;
    logic [CoordW:0]    ax, ay, az;
    logic [2*CoordW+1:0] sx, sy, sz;
    logic               sq_start, sq_busy, sq_done;
    logic [DistW:0]     sq_root;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Squared distance and match for the entry now on the memory read port.
    always_comb begin
        dx = {r_rd_data.x[CoordW-1], r_rd_data.x} - {r_key.x[CoordW-1], r_key.x};
        dy = {r_rd_data.y[CoordW-1], r_rd_data.y} - {r_key.y[CoordW-1], r_key.y};
        dz = {r_rd_data.z[CoordW-1], r_rd_data.z} - {r_key.z[CoordW-1], r_key.z};
        ax = dx[CoordW] ? -dx : dx;
        ay = dy[CoordW] ? -dy : dy;
        az = dz[CoordW] ? -dz : dz;
        sx = {{(CoordW+1){1'b0}}, ax} * {{(CoordW+1){1'b0}}, ax};
        sy = {{(CoordW+1){1'b0}}, ay} * {{(CoordW+1){1'b0}}, ay};
        sz = {{(CoordW+1){1'b0}}, az} * {{(CoordW+1){1'b0}}, az};
        n_d2 = D2W'(sx) + D2W'(sy) + D2W'(sz);
        n_match = (r_rd_data == r_key);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if ((t_opcode'(i_opcode) == OP_DELETE || t_opcode'(i_opcode) == OP_QUERY)
                        && r_count != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN:  if (r_rd_idx == r_count - 1'b1) n_state = S_DRAIN;
            S_DRAIN: n_state = (r_op == OP_QUERY) ? S_PICK : S_DONE;
            S_PICK:  n_state = r_found ? S_ROOT : S_DONE;
            S_ROOT:  if (sq_done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port and square root control.
    always_comb begin
        n_rd_addr = r_rd_idx[AddrW-1:0];
        n_we      = 1'b0;
        n_wr_addr = r_kept[AddrW-1:0];
        n_wr_data = r_rd_data;
        sq_start  = (r_state == S_PICK) && r_found;
        if (r_state == S_IDLE) begin
            n_rd_addr = '0;
            n_wr_addr = r_count[AddrW-1:0];
            n_wr_data = '{x: i_x_coord, y: i_y_coord, z: i_z_coord};
            n_we = in_acc && (t_opcode'(i_opcode) == OP_ADD)
                   && (r_count != CntW'(TABLE_DEPTH));
        end else if (r_state == S_SCAN) begin
            n_we = r_rd_live && (r_op == OP_DELETE) && !n_match;
        end else if (r_state == S_DRAIN) begin
            n_we = (r_op == OP_DELETE) && !n_match;
        end
    end

    npt_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand ({r_best, 8'd0}),
        .o_busy     (sq_busy),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LimitReset;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_live   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op      <= t_opcode'(i_opcode);
                        r_key     <= '{x: i_x_coord, y: i_y_coord, z: i_z_coord};
                        r_rd_idx  <= '0;
                        r_rd_live <= 1'b0;
                        r_kept    <= '0;
                        r_best    <= D2W'(r_limit) * D2W'(r_limit);
                        r_found   <= 1'b0;
                        r_first   <= 1'b1;
                        r_res_pt  <= '0;
                        r_res_dist   <= '0;
                        r_res_status <= ST_OK;
                        unique case (t_opcode'(i_opcode))
                            OP_CLEAR: r_count <= '0;
                            OP_ADD: begin
                                if (r_count != CntW'(TABLE_DEPTH)) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_res_status <= ST_FULL;
                                end
                            end
                            OP_QUERY: if (r_count == '0) r_res_status <= ST_EMPTY;
                            default: ;
                        endcase
                    end
                end
                S_SCAN, S_DRAIN: begin
                    // Entry r_chk_idx is on the read data this cycle.
                    if (r_state == S_SCAN) begin
                        r_rd_idx  <= r_rd_idx + 1'b1;
                        r_rd_live <= 1'b1;
                    end
                    if (r_state == S_DRAIN || r_rd_live) begin
                        if (r_op == OP_DELETE) begin
                            if (!n_match) r_kept <= r_kept + 1'b1;
                        end else begin
                            r_first <= 1'b0;
                            if (r_first || n_d2 < r_best) r_pick <= r_rd_data;
                            if (n_d2 < r_best) begin
                                r_best  <= n_d2;
                                r_found <= 1'b1;
                            end
                        end
                    end
                    if (r_state == S_DRAIN && r_op == OP_DELETE) begin
                        r_count <= n_match ? r_kept : r_kept + 1'b1;
                    end
                end
                S_PICK: begin
                    r_res_pt <= r_pick;
                    if (!r_found) r_res_dist <= DistW'({r_limit, 4'd0});
                end
                S_ROOT: if (sq_done) r_res_dist <= DistW'(sq_root);
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_count  <= r_count;
                        r_out_pt     <= r_res_pt;
                        r_out_dist   <= r_res_dist;
                        r_out_status <= r_res_status;
                    end
                end
                default: ;
            endcase
        end
    end

    // r_chk_idx tracks the entry whose data is on the read port.
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_rd_idx;
    end

    assign o_valid         = r_out_valid;
    assign o_near_x        = r_out_pt.x;
    assign o_near_y        = r_out_pt.y;
    assign o_near_z        = r_out_pt.z;
    assign o_near_distance = r_out_dist;
    assign o_point_count   = CountW'(r_out_count);
    assign o_status        = r_out_status;

    // The compacted write position never passes the entry being read.
    a_kept_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_kept <= r_chk_idx + 1'b1))
        else $error("delete write index ran ahead of read index");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(TABLE_DEPTH))
        else $error("point count above table depth");

    a_root_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_busy |-> (r_state == S_ROOT))
        else $error("square root running outside root state");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input accepted while busy");

endmodule
